// ----- design/deq_pkg.sv -----
`default_nettype none

package deq_pkg;

    // command codes
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;
    localparam logic [2:0] CMD_REVERSE    = 3'd4;

    // error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_EMPTY = 2'd1;
    localparam logic [1:0] ERR_FULL  = 2'd2;

    // fixed field widths
    localparam int WORD_W  = 64;
    localparam int COUNT_W = 7;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_LOAD
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic exec;
        logic load;
    } t_ctrl;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// ----- design/deq_ram.sv -----
`default_nettype none

module deq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ----- design/deq_ctrl.sv -----
`default_nettype none

module deq_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire deq_pkg::t_stat i_stat,
    output deq_pkg::t_ctrl      o_ctrl,
    output logic                o_in_stall
);

    deq_pkg::t_state r_state;
    deq_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= deq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            deq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = deq_pkg::S_EXEC;
                end
            end
            deq_pkg::S_EXEC: begin
                n_state = deq_pkg::S_READ;
            end
            deq_pkg::S_READ: begin
                n_state = deq_pkg::S_LOAD;
            end
            deq_pkg::S_LOAD: begin
                if (i_stat.out_free) begin
                    n_state = deq_pkg::S_IDLE;
                end
            end
        endcase
    end

    // commands to the datapath
    always_comb begin
        o_ctrl      = '0;
        o_in_stall  = 1'b1;
        unique case (r_state)
            deq_pkg::S_IDLE: begin
                o_in_stall  = 1'b0;
                o_ctrl.take = i_in_valid;
            end
            deq_pkg::S_EXEC: begin
                o_ctrl.exec = 1'b1;
            end
            deq_pkg::S_READ: begin
                o_ctrl.exec = 1'b0;
            end
            deq_pkg::S_LOAD: begin
                o_ctrl.load = i_stat.out_free;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/deq_datapath.sv -----
`default_nettype none

module deq_datapath #(
    parameter int DEPTH = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire deq_pkg::t_ctrl                i_ctrl,
    output deq_pkg::t_stat                     o_stat,
    input  wire logic [2:0]                    i_command,
    input  wire logic [deq_pkg::WORD_W-1:0]    i_push_value,
    input  wire logic                          i_out_stall,
    output logic                               o_out_valid,
    output logic      [deq_pkg::WORD_W-1:0]    o_front_value,
    output logic      [deq_pkg::WORD_W-1:0]    o_back_value,
    output logic      [deq_pkg::COUNT_W-1:0]   o_entry_count,
    output logic                               o_is_empty,
    output logic                               o_is_full,
    output logic      [1:0]                    o_error_code
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // slot that lies off places above head, wrapping around the ring
    function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] head,
                                              input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(head) + (CW+1)'(off);
        if (s >= (CW+1)'(DEPTH)) begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    logic [2:0]                 r_cmd;
    logic [deq_pkg::WORD_W-1:0] r_value;
    logic [AW-1:0]              r_head;
    logic [AW-1:0]              n_head;
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              n_count;
    logic                       r_flag;
    logic                       n_flag;
    logic [1:0]                 r_err;
    logic [1:0]                 n_err;

    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [AW-1:0]              rd_addr_high;
    logic [deq_pkg::WORD_W-1:0] rd_low;
    logic [deq_pkg::WORD_W-1:0] rd_high;

    logic                       is_empty;
    logic                       is_full;
    logic                       at_low;
    logic [31:0]                count_ext;
    logic [deq_pkg::WORD_W-1:0] low_word;
    logic [deq_pkg::WORD_W-1:0] high_word;

    logic                       r_out_valid;
    logic [deq_pkg::WORD_W-1:0] r_front;
    logic [deq_pkg::WORD_W-1:0] r_back;
    logic [deq_pkg::COUNT_W-1:0] r_cnt_out;
    logic                       r_empty_out;
    logic                       r_full_out;
    logic [1:0]                 r_err_out;

    assign is_empty = (r_count == '0);
    assign is_full  = (r_count == CW'(DEPTH));

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_ctrl.take) begin
            r_cmd   <= i_command;
            r_value <= i_push_value;
        end
    end

    // command execution: new pointers, count, direction, error code and write port
    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        n_flag  = r_flag;
        n_err   = deq_pkg::ERR_NONE;
        wr_en   = 1'b0;
        wr_addr = slot_at(r_head, r_count);
        at_low  = 1'b0;
        unique case (r_cmd)
            deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
                at_low = ((r_cmd == deq_pkg::CMD_PUSH_FRONT) == !r_flag);
                if (is_full) begin
                    n_err = deq_pkg::ERR_FULL;
                end else begin
                    wr_en   = i_ctrl.exec;
                    n_count = r_count + CW'(1);
                    if (at_low) begin
                        n_head  = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
                        wr_addr = n_head;
                    end
                end
            end
            deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK: begin
                at_low = ((r_cmd == deq_pkg::CMD_POP_FRONT) == !r_flag);
                if (is_empty) begin
                    n_err = deq_pkg::ERR_EMPTY;
                end else begin
                    n_count = r_count - CW'(1);
                    if (at_low) begin
                        n_head = slot_at(r_head, CW'(1));
                    end
                end
            end
            deq_pkg::CMD_REVERSE: begin
                if (is_empty) begin
                    n_err = deq_pkg::ERR_EMPTY;
                end else begin
                    n_flag = !r_flag;
                end
            end
            default: begin
                // unused codes leave the queue as it is
                n_err = deq_pkg::ERR_NONE;
            end
        endcase
    end

    // queue state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_flag  <= 1'b0;
        end else if (i_ctrl.exec) begin
            r_head  <= n_head;
            r_count <= n_count;
            r_flag  <= n_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.exec) begin
            r_err <= n_err;
        end
    end

    // two copies of the store give the low and the high end in one read
    assign rd_addr_high = slot_at(r_head, is_empty ? '0 : r_count - CW'(1));

    deq_ram #(
        .WIDTH (deq_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_ram_low (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_value),
        .i_rd_addr (r_head),
        .o_rd_data (rd_low)
    );

    deq_ram #(
        .WIDTH (deq_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_ram_high (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_value),
        .i_rd_addr (rd_addr_high),
        .o_rd_data (rd_high)
    );

    // result assembly
    assign low_word  = is_empty ? '0 : rd_low;
    assign high_word = is_empty ? '0 : rd_high;
    assign count_ext = 32'(r_count);

    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_front     <= r_flag ? high_word : low_word;
            r_back      <= r_flag ? low_word : high_word;
            r_cnt_out   <= count_ext[deq_pkg::COUNT_W-1:0];
            r_empty_out <= is_empty;
            r_full_out  <= is_full;
            r_err_out   <= r_err;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_front_value = r_front;
    assign o_back_value  = r_back;
    assign o_entry_count = r_cnt_out;
    assign o_is_empty    = r_empty_out;
    assign o_is_full     = r_full_out;
    assign o_error_code  = r_err_out;

endmodule

`default_nettype wire

// ----- design/double_ended_queue_core.sv -----
// Bounded double-ended queue of 64-bit words, DEPTH entries in a ring buffer.
// Input channel (i_in_valid / o_in_stall) carries one command per item:
// push front, push back, pop front, pop back or reverse; i_push_value is
// used by pushes only. Every command returns one result item on the output
// channel (o_out_valid / i_out_stall): front and back words after the
// command (zero when empty), entry count, empty and full flags, error code.
// Pop or reverse on an empty queue and push on a full queue are refused
// with an error and leave the queue unchanged.
// Each item passes through the controller sequence of execute, store read
// and output load, and the input stalls until that sequence is through;
// the next item is taken while the previous result still waits in the
// output register.
// Reverse only toggles a direction flag, so it costs no more than a pop.
// Reset empties the queue and clears the direction flag at once; the store
// itself is not cleared and is only read inside the current count.
// A stalled result holds its value; when the output register is occupied
// the block finishes the pending command and then stalls its input.
`default_nettype none

module double_ended_queue_core #(
    parameter int DEPTH = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [2:0]                  i_command,
    input  wire logic [deq_pkg::WORD_W-1:0]  i_push_value,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic      [deq_pkg::WORD_W-1:0]  o_front_value,
    output logic      [deq_pkg::WORD_W-1:0]  o_back_value,
    output logic      [deq_pkg::COUNT_W-1:0] o_entry_count,
    output logic                             o_is_empty,
    output logic                             o_is_full,
    output logic      [1:0]                  o_error_code
);

    deq_pkg::t_ctrl ctrl;
    deq_pkg::t_stat stat;

    // sequencer
    deq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_ctrl     (ctrl),
        .o_in_stall (o_in_stall)
    );

    // pointers, store and output register
    deq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .o_stat        (stat),
        .i_command     (i_command),
        .i_push_value  (i_push_value),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_front_value (o_front_value),
        .o_back_value  (o_back_value),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full),
        .o_error_code  (o_error_code)
    );

endmodule

`default_nettype wire

// ----- design/deq_checker.sv -----
`default_nettype none

module deq_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        o_in_stall,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire logic [deq_pkg::WORD_W-1:0]  o_front_value,
    input wire logic [deq_pkg::WORD_W-1:0]  o_back_value,
    input wire logic [deq_pkg::COUNT_W-1:0] o_entry_count,
    input wire logic                        o_is_empty,
    input wire logic                        o_is_full,
    input wire logic [1:0]                  o_error_code
);

    // a stalled result stays and holds its fields
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_front_value) && $stable(o_back_value)
             && $stable(o_entry_count) && $stable(o_error_code)))
        else $error("stalled result changed");

    // one command at a time: the input stalls right after an item is taken
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after item");

    // empty flag agrees with count, and an empty queue shows zero words
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_empty) |->
            (o_entry_count == '0 && o_front_value == '0 && o_back_value == '0))
        else $error("empty result with data");

    // a refused push only happens on a full queue
    a_err_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error_code == deq_pkg::ERR_FULL) |->
            (o_is_full && !o_is_empty))
        else $error("full error without full queue");

    // a refused pop or reverse only happens on an empty queue
    a_err_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error_code == deq_pkg::ERR_EMPTY) |-> o_is_empty)
        else $error("empty error on non-empty queue");

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (.*);

`default_nettype wire

// ----- sim/tb_top.sv -----
`default_nettype none

module tb_top;

    localparam int DEPTH       = 64;
    localparam int RAND_ITEMS  = 540;
    localparam int HOLD_AT     = 1200;
    localparam int HOLD_CYCLES = 300;
    localparam int LIMIT_TIME  = 8000000;

    // command codes the block leaves unused
    localparam logic [2:0] CMD_SPARE_A = 3'd5;
    localparam logic [2:0] CMD_SPARE_B = 3'd6;
    localparam logic [2:0] CMD_SPARE_C = 3'd7;

    localparam logic [63:0] WORD_ZERO = '0;
    localparam logic [63:0] WORD_ONES = '1;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } t_traffic_mode;

    // queue state as seen on the output after one command
    typedef struct packed {
        logic [deq_pkg::WORD_W-1:0]  front;
        logic [deq_pkg::WORD_W-1:0]  back;
        logic [deq_pkg::COUNT_W-1:0] count;
        logic                        empty;
        logic                        full;
        logic [1:0]                  err;
    } t_deque_view;

    // shadow copy of the ring plus the list of views still owed by the block
    class deque_tracker;
        logic [deq_pkg::WORD_W-1:0] words [DEPTH];
        bit [5:0]                   head;
        int unsigned                count;
        bit                         flipped;
        t_deque_view                pending [$];
        int                         errors;

        function new();
            head    = '0;
            count   = 0;
            flipped = 1'b0;
            errors  = 0;
        endfunction

        function void record_command(logic [2:0] cmd, logic [deq_pkg::WORD_W-1:0] val);
            t_deque_view v;
            bit          low_end;
            bit [5:0]    slot;

            v.err = deq_pkg::ERR_NONE;
            case (cmd)
                deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
                    if (count == DEPTH) begin
                        v.err = deq_pkg::ERR_FULL;
                    end else begin
                        // front is the low end of the ring unless reversed
                        low_end = ((cmd == deq_pkg::CMD_PUSH_FRONT) == !flipped);
                        if (low_end) begin
                            head = head - 6'd1;
                            words[head] = val;
                        end else begin
                            slot = head + 6'(count);
                            words[slot] = val;
                        end
                        count++;
                    end
                end
                deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK: begin
                    if (count == 0) begin
                        v.err = deq_pkg::ERR_EMPTY;
                    end else begin
                        low_end = ((cmd == deq_pkg::CMD_POP_FRONT) == !flipped);
                        if (low_end) head = head + 6'd1;
                        count--;
                    end
                end
                deq_pkg::CMD_REVERSE: begin
                    if (count == 0) v.err = deq_pkg::ERR_EMPTY;
                    else flipped = !flipped;
                end
                default: ;
            endcase

            // both ends read zero while empty
            v.front = '0;
            v.back  = '0;
            if (count != 0) begin
                slot = head + 6'(count - 1);
                v.front = flipped ? words[slot] : words[head];
                v.back  = flipped ? words[head] : words[slot];
            end
            v.count = deq_pkg::COUNT_W'(count);
            v.empty = (count == 0);
            v.full  = (count == DEPTH);
            pending.push_back(v);
        endfunction

        function void check_result(t_deque_view got);
            t_deque_view want;

            if (pending.size() == 0) begin
                $error("result item with nothing expected");
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.front !== want.front) begin
                $error("front_value expected %h actual %h", want.front, got.front);
                errors++;
            end
            if (got.back !== want.back) begin
                $error("back_value expected %h actual %h", want.back, got.back);
                errors++;
            end
            if (got.count !== want.count) begin
                $error("entry_count expected %0d actual %0d", want.count, got.count);
                errors++;
            end
            if (got.empty !== want.empty) begin
                $error("is_empty expected %b actual %b", want.empty, got.empty);
                errors++;
            end
            if (got.full !== want.full) begin
                $error("is_full expected %b actual %b", want.full, got.full);
                errors++;
            end
            if (got.err !== want.err) begin
                $error("error_code expected %0d actual %0d", want.err, got.err);
                errors++;
            end
        endfunction
    endclass

    logic                         i_clk        = 1'b0;
    logic                         i_rst_n      = 1'b0;
    logic                         i_in_valid   = 1'b0;
    logic [2:0]                   i_command    = deq_pkg::CMD_PUSH_FRONT;
    logic [deq_pkg::WORD_W-1:0]   i_push_value = '0;
    logic                         i_out_stall  = 1'b0;
    logic                         o_in_stall;
    logic                         o_out_valid;
    logic [deq_pkg::WORD_W-1:0]   o_front_value;
    logic [deq_pkg::WORD_W-1:0]   o_back_value;
    logic [deq_pkg::COUNT_W-1:0]  o_entry_count;
    logic                         o_is_empty;
    logic                         o_is_full;
    logic [1:0]                   o_error_code;

    deque_tracker tracker;
    int           src_idle_pct   = 0;
    int           sink_stall_pct = 0;
    int           items_sent     = 0;
    int           hold_left      = 0;
    bit           hold_done      = 1'b0;

    double_ended_queue_core #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_push_value  (i_push_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_front_value (o_front_value),
        .o_back_value  (o_back_value),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full),
        .o_error_code  (o_error_code)
    );

    always #10 i_clk = ~i_clk;

    // receiver stall, with one long hold-off so the block backs up
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (!hold_done && items_sent >= HOLD_AT) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            hold_done   <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < sink_stall_pct);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_result('{o_front_value, o_back_value, o_entry_count,
                                   o_is_empty, o_is_full, o_error_code});
        end
    end

    // offer one command, return at the edge that takes it
    task automatic send_command(input logic [2:0] cmd,
                                input logic [deq_pkg::WORD_W-1:0] val);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_push_value <= val;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tracker.record_command(cmd, val);
        items_sent++;
    endtask

    function automatic logic [deq_pkg::WORD_W-1:0] pick_word();
        int r;

        r = $urandom_range(99);
        if (r < 8) return WORD_ZERO;
        if (r < 16) return WORD_ONES;
        return {$urandom, $urandom};
    endfunction

    function automatic logic [2:0] pick_command(t_traffic_mode mode);
        int r;
        int push_share;

        r = $urandom_range(99);
        if (r < 3) begin
            case ($urandom_range(2))
                0:       return CMD_SPARE_A;
                1:       return CMD_SPARE_B;
                default: return CMD_SPARE_C;
            endcase
        end
        if (r < 10) return deq_pkg::CMD_REVERSE;
        case (mode)
            MODE_FILL:  push_share = 85;
            MODE_DRAIN: push_share = 12;
            default:    push_share = 50;
        endcase
        if ($urandom_range(99) < push_share)
            return $urandom_range(1) ? deq_pkg::CMD_PUSH_BACK : deq_pkg::CMD_PUSH_FRONT;
        return $urandom_range(1) ? deq_pkg::CMD_POP_BACK : deq_pkg::CMD_POP_FRONT;
    endfunction

    // bursts of filling, draining and mixed traffic so both full and empty recur
    task automatic run_traffic(input int n);
        int            counted;
        int            burst_left;
        t_traffic_mode mode;
        logic [2:0]    cmd;

        counted    = 0;
        burst_left = 0;
        mode       = MODE_MIXED;
        while (counted < n) begin
            if (burst_left == 0) begin
                mode       = t_traffic_mode'($urandom_range(2));
                burst_left = $urandom_range(40, 120);
            end
            cmd = pick_command(mode);
            send_command(cmd, pick_word());
            burst_left--;
            if (cmd <= deq_pkg::CMD_REVERSE) counted++;
        end
    endtask

    initial begin
        #(LIMIT_TIME);
        $display("double_ended_queue_core verification failed");
        $finish;
    end

    initial begin
        tracker = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: refusals on empty, extreme words, both ends, spare codes
        src_idle_pct   = 15;
        sink_stall_pct = 72;
        send_command(deq_pkg::CMD_REVERSE,    WORD_ONES);
        send_command(deq_pkg::CMD_POP_FRONT,  WORD_ONES);
        send_command(deq_pkg::CMD_POP_BACK,   WORD_ZERO);
        send_command(deq_pkg::CMD_PUSH_FRONT, WORD_ZERO);
        send_command(deq_pkg::CMD_PUSH_BACK,  WORD_ONES);
        send_command(deq_pkg::CMD_PUSH_FRONT, 64'h5555_5555_5555_5555);
        send_command(deq_pkg::CMD_PUSH_BACK,  64'haaaa_aaaa_aaaa_aaaa);
        send_command(deq_pkg::CMD_REVERSE,    WORD_ZERO);
        send_command(deq_pkg::CMD_PUSH_FRONT, 64'h0123_4567_89ab_cdef);
        send_command(deq_pkg::CMD_POP_BACK,   WORD_ZERO);
        send_command(CMD_SPARE_A,             WORD_ONES);
        send_command(CMD_SPARE_B,             WORD_ZERO);
        send_command(CMD_SPARE_C,             WORD_ONES);
        send_command(deq_pkg::CMD_POP_FRONT,  WORD_ZERO);
        send_command(deq_pkg::CMD_REVERSE,    WORD_ZERO);
        send_command(deq_pkg::CMD_PUSH_BACK,  64'hfedc_ba98_7654_3210);
        send_command(deq_pkg::CMD_POP_FRONT,  WORD_ZERO);
        send_command(deq_pkg::CMD_POP_BACK,   WORD_ZERO);
        send_command(deq_pkg::CMD_POP_FRONT,  WORD_ZERO);
        send_command(deq_pkg::CMD_POP_BACK,   WORD_ZERO);
        send_command(deq_pkg::CMD_POP_FRONT,  WORD_ZERO);
        send_command(deq_pkg::CMD_REVERSE,    WORD_ZERO);

        // random traffic, idling swapped between the two sides, then none
        run_traffic(RAND_ITEMS);
        src_idle_pct   = 72;
        sink_stall_pct = 15;
        run_traffic(RAND_ITEMS);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        run_traffic(RAND_ITEMS);
        i_in_valid <= 1'b0;

        // drain
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending.size() == 0) begin
            $display("double_ended_queue_core verification clean");
        end else begin
            $display("double_ended_queue_core verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
